// File: hw/rtl/id3tfx_pkg.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor package
// Shared result types, codes and constants for the tag parser.
// ----------------------------------------------------------------------------
package id3tfx_pkg;

	localparam int MAX_TEXT_DEF = 64;
	localparam int MAX_RES      = 4;
	localparam int RES_CNT_W    = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W    = $clog2(MAX_RES);
	localparam int Q_DEPTH      = 2;

	localparam logic [31:0] FRAME_MAX = 32'd1024;
	localparam logic [7:0]  BOM_HI    = 8'hFF;
	localparam logic [7:0]  BOM_LO    = 8'hFE;
	localparam logic [7:0]  ENC_UTF16 = 8'h01;
	localparam logic [7:0]  SYNC_MASK = 8'h7F;

	localparam logic [31:0] ID_TIT2 = 32'h54495432;
	localparam logic [31:0] ID_TPE1 = 32'h54504531;
	localparam logic [31:0] ID_TCON = 32'h54434F4E;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_TEXT    = 2'd0;
	localparam kind_t KIND_COMMIT  = 2'd1;
	localparam kind_t KIND_DISCARD = 2'd2;
	localparam kind_t KIND_FINISH  = 2'd3;

	typedef logic [1:0] field_t;
	localparam field_t FIELD_TITLE  = 2'd0;
	localparam field_t FIELD_ARTIST = 2'd1;
	localparam field_t FIELD_GENRE  = 2'd2;

	typedef struct packed {
		kind_t       kind;
		field_t      field;
		logic [7:0]  ch;
	} result_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]  cnt;
		result_t [MAX_RES-1:0] res;
	} bundle_t;

	typedef struct packed {
		logic hit;
		field_t field;
	} frame_match_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0: m = 8'h49;
			2'd1: m = 8'h44;
			default: m = 8'h33;
		endcase
		return m;
	endfunction

	function automatic frame_match_t match_frame(input logic [31:0] id);
		frame_match_t r;
		r = '{hit: 1'b0, field: FIELD_TITLE};
		priority if (id == ID_TIT2) r = '{hit: 1'b1, field: FIELD_TITLE};
		else if (id == ID_TPE1) r = '{hit: 1'b1, field: FIELD_ARTIST};
		else if (id == ID_TCON) r = '{hit: 1'b1, field: FIELD_GENRE};
		else r = '{hit: 1'b0, field: FIELD_TITLE};
		return r;
	endfunction

endpackage

// File: hw/rtl/id3tfx_front.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor front end
// Parses one file byte per beat and turns it into a bundle of results.
// ----------------------------------------------------------------------------
module id3tfx_front #(
	parameter int MAX_TEXT = id3tfx_pkg::MAX_TEXT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic                 final_byte,
	output id3tfx_pkg::bundle_t  bnd
);

	localparam int CC_W = $clog2(MAX_TEXT);
	localparam logic [CC_W-1:0] CC_LIM = CC_W'(MAX_TEXT - 1);

	typedef enum logic [2:0] {
		PH_HDR,
		PH_FHDR,
		PH_BODY,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t              phase_q, ph, ph_n;
	logic [3:0]          bidx_q, bi, bi_n;
	logic [7:0]          ver_q, ver_n;
	logic [27:0]         tsize_q, ts_n;
	logic [28:0]         tend_q, tend_n;
	logic [31:0]         fpos_q, fpos_n;
	logic [7:0]          hdr_q [8];
	logic [7:0]          hdr_n [8];
	logic [31:0]         rem_q, rem_n;
	logic [1:0]          bcnt_q, bcnt_n;
	id3tfx_pkg::field_t  field_q, field_n;
	logic                off3_q, off3_n;
	logic                gt3_q, gt3_n;
	logic [CC_W-1:0]     cc_q, cc_n;

	logic [31:0]                       fsz;
	logic [32:0]                       pos;
	logic [31:0]                       pos_sat;
	id3tfx_pkg::frame_match_t          fm;
	logic [id3tfx_pkg::RES_CNT_W-1:0]  n;
	id3tfx_pkg::result_t [id3tfx_pkg::MAX_RES-1:0] res;
	logic        dis_first, commit, fin_now, fdone, done_hit;
	logic [1:0]  tcnt;
	logic [7:0]  tb [2];

	always_comb begin
		if (ver_q >= 8'd4) begin
			fsz = {4'd0, hdr_q[4][6:0], hdr_q[5][6:0], hdr_q[6][6:0], hdr_q[7][6:0]};
		end else begin
			fsz = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
		end
		pos = {1'b0, fpos_q} + 33'd10 + {1'b0, fsz};
		pos_sat = pos[32] ? '1 : pos[31:0];
		fm = id3tfx_pkg::match_frame({hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]});
	end

	always_comb begin
		ver_n = ver_q;
		ts_n = tsize_q;
		tend_n = tend_q;
		fpos_n = fpos_q;
		hdr_n = hdr_q;
		rem_n = rem_q;
		bcnt_n = bcnt_q;
		field_n = field_q;
		off3_n = off3_q;
		gt3_n = gt3_q;
		cc_n = cc_q;
		n = '0;
		res = '0;
		commit = 1'b0;
		fin_now = 1'b0;
		fdone = 1'b0;
		done_hit = 1'b0;
		tcnt = 2'd0;
		tb[0] = data_byte;
		tb[1] = data_byte;
		dis_first = first_byte && (phase_q == PH_BODY);
		ph = first_byte ? PH_HDR : phase_q;
		bi = first_byte ? 4'd0 : bidx_q;
		ph_n = ph;
		bi_n = bi;

		unique case (ph)
			PH_HDR: begin
				if (bi < 4'd3 && data_byte != id3tfx_pkg::magic_byte(bi[1:0])) begin
					fin_now = 1'b1;
				end else begin
					if (bi == 4'd3) ver_n = data_byte;
					if (bi >= 4'd6) ts_n = {tsize_q[20:0], data_byte[6:0]};
					bi_n = bi + 4'd1;
					if (bi == 4'd9) begin
						fpos_n = 32'd10;
						tend_n = {1'b0, ts_n} + 29'd10;
						if (ts_n == '0) begin
							fin_now = 1'b1;
						end else begin
							ph_n = PH_FHDR;
							bi_n = 4'd0;
						end
					end
				end
			end
			PH_FHDR: begin
				if (bi == 4'd0 && data_byte == 8'd0) begin
					fin_now = 1'b1;
				end else begin
					if (bi < 4'd8) hdr_n[bi[2:0]] = data_byte;
					bi_n = bi + 4'd1;
					if (bi == 4'd9) begin
						fpos_n = pos_sat;
						rem_n = fsz;
						bcnt_n = 2'd0;
						if (fsz == '0) begin
							fdone = 1'b1;
							done_hit = ({3'd0, tend_q} <= pos_sat);
						end else if (fsz > id3tfx_pkg::FRAME_MAX || !fm.hit) begin
							ph_n = PH_SKIP;
						end else begin
							ph_n = PH_BODY;
							field_n = fm.field;
							cc_n = '0;
							off3_n = 1'b0;
							gt3_n = (fsz > 32'd3);
						end
					end
				end
			end
			PH_BODY: begin
				priority if (bcnt_q == 2'd0) begin
					off3_n = (data_byte == id3tfx_pkg::ENC_UTF16) && gt3_q;
				end else if (bcnt_q == 2'd1 && off3_q) begin
					if (data_byte != id3tfx_pkg::BOM_HI) begin
						off3_n = 1'b0;
						tcnt = 2'd1;
					end
				end else if (bcnt_q == 2'd2 && off3_q) begin
					if (data_byte != id3tfx_pkg::BOM_LO) begin
						off3_n = 1'b0;
						tcnt = 2'd2;
						tb[0] = id3tfx_pkg::BOM_HI;
					end
				end else begin
					tcnt = 2'd1;
				end
				rem_n = rem_q - 32'd1;
				if (bcnt_q != 2'd3) bcnt_n = bcnt_q + 2'd1;
				if (rem_q == 32'd1) begin
					commit = 1'b1;
					fdone = 1'b1;
					done_hit = ({3'd0, tend_q} <= fpos_q);
				end
			end
			PH_SKIP: begin
				rem_n = rem_q - 32'd1;
				if (rem_q == 32'd1) begin
					fdone = 1'b1;
					done_hit = ({3'd0, tend_q} <= fpos_q);
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (fdone) begin
			if (done_hit) begin
				fin_now = 1'b1;
			end else begin
				ph_n = PH_FHDR;
				bi_n = 4'd0;
			end
		end
		if (fin_now) ph_n = PH_DONE;

		if (dis_first) begin
			res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
				'{kind: id3tfx_pkg::KIND_DISCARD, field: field_q, ch: 8'd0};
			n = n + 1'b1;
		end
		for (int k = 0; k < 2; k++) begin
			if (2'(k) < tcnt && cc_n < CC_LIM) begin
				cc_n = cc_n + 1'b1;
				if (tb[k] != 8'd0) begin
					res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
						'{kind: id3tfx_pkg::KIND_TEXT, field: field_q, ch: tb[k]};
					n = n + 1'b1;
				end
			end
		end
		if (commit) begin
			res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
				'{kind: id3tfx_pkg::KIND_COMMIT, field: field_q, ch: 8'd0};
			n = n + 1'b1;
		end
		if (fin_now) begin
			res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
				'{kind: id3tfx_pkg::KIND_FINISH, field: id3tfx_pkg::FIELD_TITLE, ch: 8'd0};
			n = n + 1'b1;
		end
		if (final_byte && ph_n != PH_DONE) begin
			if (ph_n == PH_BODY) begin
				res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
					'{kind: id3tfx_pkg::KIND_DISCARD, field: field_n, ch: 8'd0};
				n = n + 1'b1;
			end
			res[n[id3tfx_pkg::RES_IDX_W-1:0]] =
				'{kind: id3tfx_pkg::KIND_FINISH, field: id3tfx_pkg::FIELD_TITLE, ch: 8'd0};
			n = n + 1'b1;
			ph_n = PH_DONE;
		end

		bnd.cnt = n;
		bnd.res = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			bidx_q <= 4'd0;
			ver_q <= 8'd0;
			tsize_q <= '0;
			tend_q <= '0;
			fpos_q <= 32'd10;
			hdr_q <= '{default: 8'd0};
			rem_q <= '0;
			bcnt_q <= 2'd0;
			field_q <= id3tfx_pkg::FIELD_TITLE;
			off3_q <= 1'b0;
			gt3_q <= 1'b0;
			cc_q <= '0;
		end else if (take) begin
			phase_q <= ph_n;
			bidx_q <= bi_n;
			ver_q <= ver_n;
			tsize_q <= ts_n;
			tend_q <= tend_n;
			fpos_q <= fpos_n;
			hdr_q <= hdr_n;
			rem_q <= rem_n;
			bcnt_q <= bcnt_n;
			field_q <= field_n;
			off3_q <= off3_n;
			gt3_q <= gt3_n;
			cc_q <= cc_n;
		end
	end

endmodule

// File: hw/rtl/id3tfx_queue.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor bundle queue
// Short FIFO of result bundles between the parser and the output serializer.
// ----------------------------------------------------------------------------
module id3tfx_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  id3tfx_pkg::bundle_t  wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 nonempty,
	output id3tfx_pkg::bundle_t  rdata
);

	localparam int PTR_W = (id3tfx_pkg::Q_DEPTH > 1) ? $clog2(id3tfx_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(id3tfx_pkg::Q_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(id3tfx_pkg::Q_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(id3tfx_pkg::Q_DEPTH);

	id3tfx_pkg::bundle_t mem_q [id3tfx_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_FULL);
	assign nonempty = (cnt_q != '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: hw/rtl/id3tfx_back.sv
// ----------------------------------------------------------------------------
// ID3 text frame extractor back end
// Serializes the head bundle onto the result channel, one result per beat.
// ----------------------------------------------------------------------------
module id3tfx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  id3tfx_pkg::bundle_t  head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output id3tfx_pkg::kind_t    kind,
	output id3tfx_pkg::field_t   field_id,
	output logic [7:0]           text_char,
	output logic                 run_end
);

	logic [id3tfx_pkg::RES_IDX_W-1:0] idx_q;
	id3tfx_pkg::result_t sel;
	logic beat;

	assign sel = head.res[idx_q];
	assign result_valid = head_valid;
	assign kind = sel.kind;
	assign field_id = sel.field;
	assign text_char = sel.ch;
	assign run_end = ({1'b0, idx_q} + 1'b1) == head.cnt;
	assign beat = result_valid && result_ready;
	assign pop = beat && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= run_end ? '0 : idx_q + 1'b1;
		end
	end

endmodule

// File: hw/rtl/id3v2_text_frame_extractor.sv
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor
// Parses the ID3v2 tag of a byte stream and emits title, artist and genre text.
// ----------------------------------------------------------------------------
// Each byte's results are registered in the queue and reach the result port
// once the earlier bundles are delivered. Throughput: one byte per cycle; a
// byte with k results takes k beats of the result port, and the two-bundle
// queue stalls the input when it is full. Reset is asynchronous: the parser
// waits for a tag header and the queue is empty.
module id3v2_text_frame_extractor #(
	parameter int MAX_TEXT = id3tfx_pkg::MAX_TEXT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                final_byte,
	output logic                result_valid,
	input  logic                result_ready,
	output id3tfx_pkg::kind_t   kind,
	output id3tfx_pkg::field_t  field_id,
	output logic [7:0]          text_char,
	output logic                run_end
);

	id3tfx_pkg::bundle_t bnd, head;
	logic take, full, nonempty, pop;

	assign byte_ready = !full;
	assign take = byte_valid && byte_ready;

	id3tfx_front #(
		.MAX_TEXT(MAX_TEXT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(data_byte),
		.first_byte(first_byte),
		.final_byte(final_byte),
		.bnd(bnd)
	);

	id3tfx_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(take && (bnd.cnt != '0)),
		.wdata(bnd),
		.full(full),
		.pop(pop),
		.nonempty(nonempty),
		.rdata(head)
	);

	id3tfx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(nonempty),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.field_id(field_id),
		.text_char(text_char),
		.run_end(run_end)
	);

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == id3tfx_pkg::KIND_FINISH |-> run_end)
		else $error("tag finished result is not the last of its byte");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> field_id != 2'd3)
		else $error("field id out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("input stalled with nothing to deliver");

	a_pop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> result_ready && run_end)
		else $error("bundle released before its last result");

endmodule
